// ===== rtl/core/qte_pkg.sv =====
// qte_pkg: shared widths, constants, vector type and arctangent table for the
// quaternion to euler converter; no dependencies
`timescale 1ns / 1ps
package qte_pkg;

   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned TAB_LEN          = 24;

   localparam int unsigned CW        = 36;  // cordic x/y width
   localparam int unsigned ZW        = 35;  // angle accumulator, radians q.30
   localparam int unsigned DW        = 61;  // isqrt operand width
   localparam int unsigned RW        = 62;  // isqrt working width
   localparam int unsigned SQRT_BITS = 31;
   localparam int unsigned SQRT_LAT  = SQRT_BITS + 1;

   localparam logic signed [ZW-1:0] PI_Q30          = 35'sd3373259426;
   localparam logic        [21:0]   DEG_PER_RAD_Q16 = 22'd3754936;
   localparam logic        [DW-1:0] ONE_SQ_Q60      = 61'd1 << 60;

   typedef struct packed {
      logic signed [CW-1:0] xv;
      logic signed [CW-1:0] yv;
   } vec_type;

   function automatic int unsigned eff_steps(input int unsigned steps);
      return (steps > TAB_LEN) ? TAB_LEN : steps;
   endfunction

   // atan(2^-i) in radians q.30
   function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
      logic [ZW-1:0] r;
      unique case (idx)
         0:  r = 35'h3243F6A8;
         1:  r = 35'h1DAC6705;
         2:  r = 35'h0FADBAFC;
         3:  r = 35'h07F56EA6;
         4:  r = 35'h03FEAB76;
         5:  r = 35'h01FFD55B;
         6:  r = 35'h00FFFAAA;
         7:  r = 35'h007FFF55;
         8:  r = 35'h003FFFEA;
         9:  r = 35'h001FFFFD;
         10: r = 35'h000FFFFF;
         11: r = 35'h0007FFFF;
         12: r = 35'h0003FFFF;
         13: r = 35'h0001FFFF;
         14: r = 35'h0000FFFF;
         15: r = 35'h00007FFF;
         16: r = 35'h00003FFF;
         17: r = 35'h00001FFF;
         18: r = 35'h00000FFF;
         19: r = 35'h000007FF;
         20: r = 35'h000003FF;
         21: r = 35'h000001FF;
         22: r = 35'h000000FF;
         23: r = 35'h0000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/qte_isqrt.sv =====
// qte_isqrt: pipelined floor square root, one result bit per stage
// depends on qte_pkg
`timescale 1ns / 1ps
module qte_isqrt import qte_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [DW-1:0]        in_val,
   output logic                 out_valid,
   output logic [SQRT_BITS-1:0] out_root
);

   logic          valid_ff [0:SQRT_BITS];
   logic [RW-1:0] rem_ff   [0:SQRT_BITS];
   logic [RW-1:0] root_ff  [0:SQRT_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0]  <= RW'(in_val);
      root_ff[0] <= '0;
   end

   for (genvar k = 0; k < SQRT_BITS; k++) begin : g_stage
      localparam int unsigned SH = 2 * (SQRT_BITS - 1 - k);
      logic [RW-1:0] bit_val;
      logic [RW-1:0] trial;
      assign bit_val = RW'(1) << SH;
      assign trial   = root_ff[k] + bit_val;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (rem_ff[k] >= trial) begin
            rem_ff[k+1]  <= rem_ff[k] - trial;
            root_ff[k+1] <= (root_ff[k] >> 1) + bit_val;
         end else begin
            rem_ff[k+1]  <= rem_ff[k];
            root_ff[k+1] <= root_ff[k] >> 1;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_BITS];
   assign out_root  = root_ff[SQRT_BITS][SQRT_BITS-1:0];

endmodule

// ===== rtl/core/qte_cordic.sv =====
// qte_cordic: pipelined vectoring cordic atan2, one iteration per stage
// depends on qte_pkg
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; #(
   parameter int unsigned STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  vec_type              in_vec,
   output logic                 out_valid,
   output logic signed [ZW-1:0] out_angle
);

   localparam int unsigned N = eff_steps(STEPS);

   logic                 valid_ff [0:N];
   logic                 zero_ff  [0:N];
   logic signed [CW-1:0] x_ff     [0:N];
   logic signed [CW-1:0] y_ff     [0:N];
   logic signed [ZW-1:0] z_ff     [0:N];

   logic                 zero_in;
   logic signed [CW-1:0] x_in;
   logic signed [CW-1:0] y_in;
   logic signed [ZW-1:0] z_in;

   // left half plane: mirror through origin, start at +-pi
   always_comb begin
      zero_in = (in_vec.xv == '0) && (in_vec.yv == '0);
      if (in_vec.xv[CW-1]) begin
         x_in = -in_vec.xv;
         y_in = -in_vec.yv;
         z_in = in_vec.yv[CW-1] ? -PI_Q30 : PI_Q30;
      end else begin
         x_in = in_vec.xv;
         y_in = in_vec.yv;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      zero_ff[0] <= zero_in;
      x_ff[0]    <= x_in;
      y_ff[0]    <= y_in;
      z_ff[0]    <= z_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] step_angle;
      assign dx         = y_ff[i] >>> i;
      assign dy         = x_ff[i] >>> i;
      assign step_angle = $signed(atan_entry(i));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         zero_ff[i+1] <= zero_ff[i];
         if (!y_ff[i][CW-1]) begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + step_angle;
         end else begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - step_angle;
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_angle = zero_ff[N] ? '0 : z_ff[N];

endmodule

// ===== rtl/core/quaternion_to_euler.sv =====
// quaternion_to_euler: top level, quaternion q1.15 to xyz euler angles
// depends on qte_pkg, qte_isqrt, qte_cordic
`timescale 1ns / 1ps
//
// usage
//   input: drive req_quat_w/x/y/z and pulse start; a transfer happens at each
//   rising edge with start high and busy low. busy is always low, so a new
//   quaternion may be sent every cycle.
//   result: rsp_strobe is high for exactly one cycle with rsp_angle_x/y/z and
//   rsp_asin_saturated; the receiver cannot stall and must take it then.
//   stages: from the input transfer to the strobe, 3 product/sum stages, 2 for
//   the asin cosine square, 32 for the bit-per-stage square root, CORDIC_STEPS
//   + 1 cordic stages (steps capped at the atan table), 2 unit conversion.
//   throughput: one item per cycle; every unit is fully pipelined and the
//   latency is set by the square root and cordic stage count.
//   config: csr_wr_en writes csr_wr_data into angle_unit (0 radians q3.14,
//   1 degrees q9.8); write only while nothing is in flight.
//   reset: clears all valid bits and angle_unit; in-flight items are dropped.
//
module quaternion_to_euler import qte_pkg::*; #(
   parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output logic               rsp_strobe,
   output logic signed [16:0] rsp_angle_x,
   output logic signed [16:0] rsp_angle_y,
   output logic signed [16:0] rsp_angle_z,
   output logic               rsp_asin_saturated
);

   localparam int unsigned N          = eff_steps(CORDIC_STEPS);
   localparam int unsigned SIDE_DEPTH = 2 + SQRT_LAT;
   localparam int unsigned SAT_DEPTH  = SIDE_DEPTH + N + 3;

   localparam logic signed [33:0] S_ONE     = 34'sd1073741824;
   localparam logic signed [21:0] OUT_MAX   = 22'sd65535;
   localparam logic signed [21:0] OUT_MIN   = -22'sd65536;
   localparam logic signed [59:0] DEG_ROUND = 60'sd1 <<< 37;
   localparam logic signed [ZW-1:0] RAD_ROUND = 35'sd32768;

   typedef struct packed {
      vec_type              ax;
      vec_type              az;
      logic signed [31:0]   s;
   } side_type;

   // config register
   logic angle_unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_unit_ff <= 1'b0;
      end else if (csr_wr_en) begin
         angle_unit_ff <= csr_wr_data;
      end
   end

   // never stalls, every cycle can take a transfer
   assign busy = 1'b0;

   // stage 1: input register
   logic               v1_ff;
   logic signed [15:0] w1_ff, x1_ff, y1_ff, z1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      w1_ff <= req_quat_w;
      x1_ff <= req_quat_x;
      y1_ff <= req_quat_y;
      z1_ff <= req_quat_z;
   end

   // stage 2: all pairwise products at q.30
   logic               v2_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [31:0] yz_ff, xw_ff, xy_ff, zw_ff, yw_ff, xz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      ww_ff <= w1_ff * w1_ff;
      xx_ff <= x1_ff * x1_ff;
      yy_ff <= y1_ff * y1_ff;
      zz_ff <= z1_ff * z1_ff;
      yz_ff <= y1_ff * z1_ff;
      xw_ff <= x1_ff * w1_ff;
      xy_ff <= x1_ff * y1_ff;
      zw_ff <= z1_ff * w1_ff;
      yw_ff <= y1_ff * w1_ff;
      xz_ff <= x1_ff * z1_ff;
   end

   // stage 3: atan2 operands and clamped asin argument
   vec_type            ax_in, az_in;
   logic signed [33:0] s_full;
   logic signed [31:0] s_in;
   logic               sat_in;

   always_comb begin
      ax_in.yv = (CW'(yz_ff) + CW'(xw_ff)) <<< 1;
      ax_in.xv = CW'(ww_ff) - CW'(xx_ff) - CW'(yy_ff) + CW'(zz_ff);
      az_in.yv = (CW'(xy_ff) + CW'(zw_ff)) <<< 1;
      az_in.xv = CW'(ww_ff) + CW'(xx_ff) - CW'(yy_ff) - CW'(zz_ff);
      s_full   = (34'(yw_ff) - 34'(xz_ff)) <<< 1;
      priority if (s_full > S_ONE) begin
         s_in   = 32'(S_ONE);
         sat_in = 1'b1;
      end else if (s_full < -S_ONE) begin
         s_in   = 32'(-S_ONE);
         sat_in = 1'b1;
      end else begin
         s_in   = 32'(s_full);
         sat_in = 1'b0;
      end
   end

   logic               v3_ff;
   vec_type            ax3_ff, az3_ff;
   logic signed [31:0] s3_ff;
   logic               sat3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      ax3_ff  <= ax_in;
      az3_ff  <= az_in;
      s3_ff   <= s_in;
      sat3_ff <= sat_in;
   end

   // stage 4: s squared, q.60
   logic signed [63:0] s_sq;
   logic               v4_ff;
   logic [DW-1:0]      sq4_ff;

   assign s_sq = s3_ff * s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      sq4_ff <= s_sq[DW-1:0];
   end

   // stage 5: cos^2 = 1 - s^2
   logic          v5_ff;
   logic [DW-1:0] d5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      d5_ff <= ONE_SQ_Q60 - sq4_ff;
   end

   logic                 root_valid;
   logic [SQRT_BITS-1:0] root;

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_val    (d5_ff),
      .out_valid (root_valid),
      .out_root  (root)
   );

   // atan2 operands wait here for the square root
   side_type side_ff [0:SIDE_DEPTH-1];
   logic     sat_ff  [0:SAT_DEPTH-1];

   always_ff @(posedge clock) begin
      side_ff[0] <= '{ax: ax3_ff, az: az3_ff, s: s3_ff};
      sat_ff[0]  <= sat3_ff;
   end

   for (genvar k = 1; k < SIDE_DEPTH; k++) begin : g_side
      always_ff @(posedge clock) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   for (genvar k = 1; k < SAT_DEPTH; k++) begin : g_sat
      always_ff @(posedge clock) begin
         sat_ff[k] <= sat_ff[k-1];
      end
   end

   side_type side_out;
   vec_type  ay_vec;

   assign side_out  = side_ff[SIDE_DEPTH-1];
   assign ay_vec.xv = CW'({1'b0, root});
   assign ay_vec.yv = CW'(side_out.s);

   // three cordics in lockstep; x, y, z angle order
   logic                 cordic_valid [0:2];
   logic signed [ZW-1:0] cordic_angle [0:2];
   vec_type              cordic_in    [0:2];

   assign cordic_in[0] = side_out.ax;
   assign cordic_in[1] = ay_vec;
   assign cordic_in[2] = side_out.az;

   for (genvar a = 0; a < 3; a++) begin : g_cordic
      qte_cordic #(
         .STEPS (CORDIC_STEPS)
      ) u_cordic (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (root_valid),
         .in_vec    (cordic_in[a]),
         .out_valid (cordic_valid[a]),
         .out_angle (cordic_angle[a])
      );
   end

   // stage a: register the radian angle and split degree scaling into two partial products
   logic                 va_ff;
   logic signed [ZW-1:0] za_ff  [0:2];
   logic        [37:0]   plo_ff [0:2];
   logic signed [41:0]   phi_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= cordic_valid[0];
      end
   end

   // stage b: round, pick unit, saturate
   logic               vb_ff;
   logic signed [16:0] angle_ff [0:2];

   for (genvar a = 0; a < 3; a++) begin : g_conv
      logic signed [59:0]   deg_sum;
      logic signed [21:0]   deg_q;
      logic signed [ZW-1:0] rad_sum;
      logic signed [21:0]   rad_q;
      logic signed [21:0]   pick;
      logic signed [16:0]   sat_val;

      always_ff @(posedge clock) begin
         za_ff[a]  <= cordic_angle[a];
         plo_ff[a] <= cordic_angle[a][15:0] * DEG_PER_RAD_Q16;
         phi_ff[a] <= $signed(cordic_angle[a][ZW-1:16]) * $signed({1'b0, DEG_PER_RAD_Q16});
      end

      always_comb begin
         deg_sum = (60'(phi_ff[a]) <<< 16) + $signed(60'(plo_ff[a])) + DEG_ROUND;
         deg_q   = 22'(deg_sum >>> 38);
         rad_sum = za_ff[a] + RAD_ROUND;
         rad_q   = 22'(rad_sum >>> 16);
         pick    = angle_unit_ff ? deg_q : rad_q;
         priority if (pick > OUT_MAX) begin
            sat_val = 17'(OUT_MAX);
         end else if (pick < OUT_MIN) begin
            sat_val = 17'(OUT_MIN);
         end else begin
            sat_val = 17'(pick);
         end
      end

      always_ff @(posedge clock) begin
         angle_ff[a] <= sat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
   end

   assign rsp_strobe         = vb_ff;
   assign rsp_angle_x        = angle_ff[0];
   assign rsp_angle_y        = angle_ff[1];
   assign rsp_angle_z        = angle_ff[2];
   assign rsp_asin_saturated = sat_ff[SAT_DEPTH-1];

endmodule

// ===== verif/tb_quaternion_to_euler.sv =====
// tb_quaternion_to_euler: self-checking bench for the quaternion to euler converter
// depends on qte_pkg and quaternion_to_euler; predicts angle sets in-bench, but for typed-in rows
`timescale 1ns / 1ps
module tb_quaternion_to_euler import qte_pkg::*;;

   localparam int unsigned STEPS   = 16;
   localparam int unsigned LATENCY = STEPS + 40;
   localparam int          N_RAND  = 1550;
   localparam longint      LIMIT   = 400000;
   localparam longint      PI_RAD  = 64'sd3373259426;
   localparam longint      ONE_RAD = 64'sd1073741824;
   localparam longint      DEG_Q16 = 64'sd3754936;

   typedef enum logic {UNIT_RAD = 1'b0, UNIT_DEG = 1'b1} unit_type;

   typedef struct packed {
      logic signed [16:0] ax;
      logic signed [16:0] ay;
      logic signed [16:0] az;
      logic               sat;
   } angles_type;

   // directed row: quaternion, whether the result is typed in, and that result
   typedef struct {
      logic signed [15:0] w, x, y, z;
      bit                 fixed;
      angles_type         res;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;
   logic               rsp_strobe;
   logic signed [16:0] rsp_angle_x, rsp_angle_y, rsp_angle_z;
   logic               rsp_asin_saturated;

   unit_type   unit_mirror = UNIT_RAD;
   angles_type angles_pending[$];
   int         mismatches = 0;
   int         results_seen = 0;
   int         items_sent = 0;
   longint     cycle_count = 0;
   int         idle_pct = 0;

   quaternion_to_euler #(.CORDIC_STEPS(STEPS)) dut (
      .clock, .reset, .start, .busy,
      .req_quat_w, .req_quat_x, .req_quat_y, .req_quat_z,
      .csr_wr_en, .csr_wr_data,
      .rsp_strobe, .rsp_angle_x, .rsp_angle_y, .rsp_angle_z, .rsp_asin_saturated
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // floor division by a power of two
   function automatic longint floor_shift(input longint v, input int s);
      return (v < 0) ? ~((~v) >>> s) : (v >>> s);
   endfunction

   function automatic longint root_floor(input longint unsigned v);
      longint unsigned rem, root, b;
      rem = v; root = 0; b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   // vectoring cordic, result in radians q.30
   function automatic longint vector_angle(input longint yv, input longint xv);
      longint base, acc, dx, dy;
      base = 0; acc = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         base = (yv < 0) ? -PI_RAD : PI_RAD;
         xv = -xv;
         yv = -yv;
      end
      for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
         dx = floor_shift(yv, i);
         dy = floor_shift(xv, i);
         if (yv >= 0) begin
            xv += dx; yv -= dy; acc += longint'(atan_entry(i));
         end else begin
            xv -= dx; yv += dy; acc -= longint'(atan_entry(i));
         end
      end
      return base + acc;
   endfunction

   function automatic logic signed [16:0] scale_angle(input longint a);
      longint r;
      if (unit_mirror == UNIT_RAD) r = floor_shift(a + (64'sd1 <<< 15), 16);
      else r = floor_shift(a * DEG_Q16 + (64'sd1 <<< 37), 38);
      if (r > 65535) r = 65535;
      if (r < -65536) r = -65536;
      return r[16:0];
   endfunction

   function automatic angles_type euler_angles(input logic signed [15:0] qw, qx, qy, qz);
      longint w, x, y, z, s;
      angles_type a;
      w = qw; x = qx; y = qy; z = qz;
      a.ax = scale_angle(vector_angle(2 * (y * z + x * w), w*w - x*x - y*y + z*z));
      a.az = scale_angle(vector_angle(2 * (x * y + z * w), w*w + x*x - y*y - z*z));
      s = 2 * (y * w - x * z);
      a.sat = 1'b0;
      // asin argument beyond unit magnitude is clamped and flagged
      if (s > ONE_RAD) begin
         s = ONE_RAD; a.sat = 1'b1;
      end else if (s < -ONE_RAD) begin
         s = -ONE_RAD; a.sat = 1'b1;
      end
      a.ay = scale_angle(vector_angle(s, root_floor((64'd1 << 60) - s * s)));
      return a;
   endfunction

   // result checker; strobe cannot be stalled, so every strobe is a transfer
   always @(posedge clock) begin
      angles_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (angles_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
         end else begin
            want = angles_pending.pop_front();
            if (rsp_angle_x !== want.ax || rsp_angle_y !== want.ay ||
                rsp_angle_z !== want.az || rsp_asin_saturated !== want.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp x=%0d y=%0d z=%0d sat=%0b",
                            " got x=%0d y=%0d z=%0d sat=%0b"},
                           want.ax, want.ay, want.az, want.sat,
                           rsp_angle_x, rsp_angle_y, rsp_angle_z, rsp_asin_saturated);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_quaternion_to_euler: done, errors");
         $finish;
      end
   end

   // one quaternion transfer; start stays high across back-to-back items
   task automatic send_quat(input logic signed [15:0] w, x, y, z, input bit fixed = 0,
                            input angles_type res = '0);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      angles_pending.push_back(fixed ? res : euler_angles(w, x, y, z));
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // drain everything in flight, then let the pipeline go quiet
   task automatic drain_pipe();
      start <= 1'b0;
      @(posedge clock);
      while (angles_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_unit(input unit_type u);
      csr_wr_en <= 1'b1;
      csr_wr_data <= u;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      unit_mirror = u;
   endtask

   // a quaternion with one full-scale component at a random position, or fully random noise
   task automatic send_random();
      logic signed [15:0] q[4];
      int k;
      if ($urandom_range(3, 0) != 0) begin
         k = $urandom_range(3, 0);
         foreach (q[i]) q[i] = $signed(16'($urandom_range(23170, 0))) *
                               ($urandom_range(1, 0) ? 1 : -1);
         q[k] = $urandom_range(1, 0) ? 16'sd32767 : -16'sd32768;
         q[(k + 1) % 4] = $signed(16'($urandom)) >>> $urandom_range(6, 0);
      end else begin
         foreach (q[i]) q[i] = $signed(16'($urandom));
      end
      send_quat(q[0], q[1], q[2], q[3]);
   endtask

   initial begin
      row_type rows[$];
      angles_type zero_res;
      zero_res = '0;
      // identity and zero vector read straight off; the rest predicted
      rows = '{
         '{16'sd0,      16'sd0,      16'sd0,      16'sd0,      1, zero_res},
         '{16'sd32767,  16'sd0,      16'sd0,      16'sd0,      1, zero_res},
         '{-16'sd32768, 16'sd0,      16'sd0,      16'sd0,      1, zero_res},
         '{16'sd0,      16'sd32767,  16'sd0,      16'sd0,      0, zero_res},
         '{16'sd0,      16'sd0,      16'sd32767,  16'sd0,      0, zero_res},
         '{16'sd0,      16'sd0,      16'sd0,      16'sd32767,  0, zero_res},
         '{16'sd0,      -16'sd32768, 16'sd0,      16'sd0,      0, zero_res},
         '{16'sd0,      16'sd0,      -16'sd32768, 16'sd0,      0, zero_res},
         '{16'sd0,      16'sd0,      16'sd0,      -16'sd32768, 0, zero_res},
         '{16'sd23170,  16'sd0,      16'sd23170,  16'sd0,      0, zero_res},
         '{16'sd23170,  16'sd0,      -16'sd23170, 16'sd0,      0, zero_res},
         '{16'sd32767,  16'sd32767,  16'sd32767,  16'sd32767,  0, zero_res},
         '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, zero_res},
         '{16'sd32767,  -16'sd32768, 16'sd32767,  -16'sd32768, 0, zero_res},
         '{-16'sd32768, 16'sd32767,  16'sd32767,  16'sd32767,  0, zero_res},
         '{16'sd16384,  16'sd16384,  16'sd16384,  16'sd16384,  0, zero_res},
         '{16'sd1,      -16'sd1,     16'sd1,      -16'sd1,     0, zero_res},
         '{16'sd0,      16'sd23170,  16'sd0,      16'sd23170,  0, zero_res},
         '{16'sd21845,  -16'sd21845, 16'sd10000,  16'sd5000,   0, zero_res},
         '{-16'sd1,     16'sd0,      16'sd0,      16'sd0,      0, zero_res}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows in radians, then again in degrees
      foreach (rows[i]) send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                                  rows[i].fixed, rows[i].res);
      drain_pipe();
      write_unit(UNIT_DEG);
      foreach (rows[i]) send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z);
      drain_pipe();

      // random phases alternate the unit; the drain between them is the full pause
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 77 : (ph == 3) ? 21 : 0;
         write_unit(unit_type'(ph[0]));
         for (int n = 0; n < N_RAND / 4; n++) send_random();
         drain_pipe();
      end

      $display("covered %0d quaternions, %0d angle sets checked, both units, idle 0/21/77%%",
               items_sent, results_seen);
      if (mismatches == 0 && angles_pending.size() == 0) begin
         $display("tb_quaternion_to_euler: done, clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, angles_pending.size());
         $display("tb_quaternion_to_euler: done, errors");
      end
      $finish;
   end

endmodule
